@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl top level json_string_unescape_utf8
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/jsu_pkg.sv @@
// shared types and constants for the json string unescaper
// no dependencies
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int unsigned MaxBurst = 3;

    localparam logic [7:0] Utf8Lead2 = 8'hC0;
    localparam logic [7:0] Utf8Lead3 = 8'hE0;
    localparam logic [7:0] Utf8Cont  = 8'h80;
    localparam logic [5:0] Utf8Mask  = 6'h3F;
    localparam logic [15:0] Utf8Limit2 = 16'h0800;
    localparam logic [15:0] Utf8Limit1 = 16'h0080;

    // decoded bytes of one input byte, first byte in element 0
    typedef struct packed {
        logic [1:0]                   count;
        logic [MaxBurst-1:0][7:0]     bytes;
    } burst_t;

endpackage

@@ hw/rtl/jsu_escaped_if.sv @@
// escaped byte channel: valid/ready handshake with byte and start flag
// no dependencies
`timescale 1ns / 1ps

interface jsu_escaped_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_value;

    modport source (output valid, output in_byte, output start_value, input ready);
    modport sink (input valid, input in_byte, input start_value, output ready);
endinterface

@@ hw/rtl/jsu_decoded_if.sv @@
// decoded byte channel: valid/ready handshake with byte and run end flag
// no dependencies
`timescale 1ns / 1ps

interface jsu_decoded_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ hw/rtl/json_string_unescape_utf8.sv @@
// A byte is taken every cycle while escapes yield at most one output byte and the
// output is ready; a \uXXXX that encodes to 2 or 3 UTF-8 bytes holds the input until
// its last byte shows, since the single output byte port sends one byte per transfer.
// start_value clears the decoder for that byte. Data passes s1 and the burst register.
// depends on jsu_pkg, jsu_escaped_if, jsu_decoded_if, jsu_decode, jsu_burst
`timescale 1ns / 1ps

`include "assert_macros.svh"

module json_string_unescape_utf8
(
    input  logic          clk,
    input  logic          rst_n,
    jsu_escaped_if.sink   escaped,
    jsu_decoded_if.source decoded
);
    import jsu_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       s1_advance;
    logic       can_load;
    logic       in_take;
    burst_t     burst;

    assign s1_advance    = s1_valid_reg && can_load;
    assign escaped.ready = !s1_valid_reg || can_load;
    assign in_take       = escaped.valid && escaped.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= escaped.in_byte;
            s1_start_reg <= escaped.start_value;
        end
    end

    jsu_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_byte  (s1_byte_reg),
        .item_start (s1_start_reg),
        .advance    (s1_advance),
        .burst      (burst)
    );

    jsu_burst u_burst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_burst (burst),
        .load_en    (s1_advance),
        .can_load   (can_load),
        .decoded    (decoded)
    );

    // a held item must move on when a new one is taken
    `ASSERT_SAME(a_no_overwrite, in_take && s1_valid_reg, s1_advance)
    // a non-empty burst shows up on the output next cycle
    `ASSERT_NEXT(a_burst_shown, s1_advance && burst.count != 2'd0, decoded.valid)
    // an empty burst leaves the output idle
    `ASSERT_NEXT(a_empty_idle, s1_advance && burst.count == 2'd0, !decoded.valid)

endmodule

@@ hw/rtl/jsu_decode.sv @@
// escape decoder: mode state and the byte-to-burst logic
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      item_byte,
    input  logic            item_start,
    input  logic            advance,
    output jsu_pkg::burst_t burst
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_ENDED
    } mode_t;

    mode_t       mode_reg, mode_next, mode_cur;
    logic [1:0]  count_reg, count_next, count_cur;
    logic [15:0] code_reg, code_next, code_cur;
    logic        stop_reg, stop_next, stop_cur;

    logic [4:0]  digit;
    logic [15:0] code_new;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= "0" && c <= "9") d = {1'b0, 4'(c - "0")};
        else if (c >= "a" && c <= "f") d = {1'b0, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F") d = {1'b0, 4'(c - "A" + 8'd10)};
        return d;
    endfunction

    always_comb
    begin
        mode_cur  = item_start ? MODE_NORMAL : mode_reg;
        count_cur = item_start ? 2'd0 : count_reg;
        code_cur  = item_start ? 16'd0 : code_reg;
        stop_cur  = item_start ? 1'b0 : stop_reg;

        mode_next  = mode_cur;
        count_next = count_cur;
        code_next  = code_cur;
        stop_next  = stop_cur;
        burst      = '0;

        digit    = hex_digit(item_byte);
        code_new = code_cur;

        unique case (mode_cur)
            MODE_NORMAL:
            begin
                if (item_byte == 8'h00 || item_byte == "\"")
                    mode_next = MODE_ENDED;
                else if (item_byte == "\\")
                    mode_next = MODE_ESCAPE;
                else
                begin
                    burst.count    = 2'd1;
                    burst.bytes[0] = item_byte;
                end
            end
            MODE_ESCAPE:
            begin
                mode_next   = MODE_NORMAL;
                burst.count = 2'd1;
                case (item_byte)
                    "n":     burst.bytes[0] = 8'h0A;
                    "t":     burst.bytes[0] = 8'h09;
                    "r":     burst.bytes[0] = 8'h0D;
                    "u":
                    begin
                        burst.count = 2'd0;
                        mode_next   = MODE_HEX;
                        count_next  = 2'd0;
                        code_next   = 16'd0;
                        stop_next   = 1'b0;
                    end
                    8'h00:
                    begin
                        burst.bytes[0] = 8'h00;
                        mode_next      = MODE_ENDED;
                    end
                    default: burst.bytes[0] = item_byte;
                endcase
            end
            MODE_HEX:
            begin
                if (item_byte == 8'h00)
                begin
                    mode_next  = MODE_ENDED;
                    count_next = 2'd0;
                end
                else
                begin
                    if (!stop_cur)
                    begin
                        if (digit[4])
                            stop_next = 1'b1;
                        else
                            code_new = {code_cur[11:0], digit[3:0]};
                    end
                    code_next  = code_new;
                    count_next = count_cur + 2'd1;
                    if (count_cur == 2'd3)
                    begin
                        mode_next  = MODE_NORMAL;
                        count_next = 2'd0;
                        if (code_new < Utf8Limit1)
                        begin
                            burst.count    = 2'd1;
                            burst.bytes[0] = code_new[7:0];
                        end
                        else if (code_new < Utf8Limit2)
                        begin
                            burst.count    = 2'd2;
                            burst.bytes[0] = Utf8Lead2 | {3'b000, code_new[10:6]};
                            burst.bytes[1] = Utf8Cont | {2'b00, code_new[5:0] & Utf8Mask};
                        end
                        else
                        begin
                            burst.count    = 2'd3;
                            burst.bytes[0] = Utf8Lead3 | {4'h0, code_new[15:12]};
                            burst.bytes[1] = Utf8Cont | {2'b00, code_new[11:6] & Utf8Mask};
                            burst.bytes[2] = Utf8Cont | {2'b00, code_new[5:0] & Utf8Mask};
                        end
                    end
                end
            end
            MODE_ENDED:
            begin
                burst.count = 2'd0;
            end
            default:
            begin
                burst.count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= 2'd0;
            code_reg  <= 16'd0;
            stop_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            code_reg  <= code_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

@@ hw/rtl/jsu_burst.sv @@
// result register: holds one burst and sends it a byte per transfer
// depends on jsu_pkg and jsu_decoded_if
`timescale 1ns / 1ps

module jsu_burst
(
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::burst_t load_burst,
    input  logic            load_en,
    output logic            can_load,
    jsu_decoded_if.source   decoded
);
    import jsu_pkg::*;

    logic [MaxBurst-1:0][7:0] bytes_reg;
    logic [1:0]               left_reg;
    logic [1:0]               idx_reg;
    logic                     take;

    assign decoded.valid       = (left_reg != 2'd0);
    assign decoded.last_of_run = (left_reg == 2'd1);
    assign take                = decoded.valid && decoded.ready;
    assign can_load            = (left_reg == 2'd0) || (left_reg == 2'd1 && decoded.ready);

    always_comb
    begin
        case (idx_reg)
            2'd1:    decoded.out_byte = bytes_reg[1];
            2'd2:    decoded.out_byte = bytes_reg[2];
            default: decoded.out_byte = bytes_reg[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else if (load_en)
        begin
            left_reg <= load_burst.count;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            left_reg <= left_reg - 2'd1;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            bytes_reg <= load_burst.bytes;
    end

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for json_string_unescape_utf8: drives escaped bytes, predicts the
// decoded utf-8 stream in a local decoder model and checks every output transfer in order
// depends on jsu_pkg, jsu_escaped_if, jsu_decoded_if and the rtl top level
`timescale 1ns / 1ps

module testbench;
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        ModeText   = 2'd0,
        ModeEscape = 2'd1,
        ModeHex    = 2'd2,
        ModeEnded  = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    localparam logic [7:0] ChNul       = 8'h00;
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChLetterN   = 8'h6E;
    localparam logic [7:0] ChLetterT   = 8'h74;
    localparam logic [7:0] ChLetterR   = 8'h72;
    localparam logic [7:0] ChLetterU   = 8'h75;
    localparam logic [7:0] ChLetterX   = 8'h78;
    localparam logic [7:0] ChLetterZ   = 8'h7A;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChReturn    = 8'h0D;
    localparam logic [7:0] ChDigit0    = 8'h30;
    localparam logic [7:0] ChLowerA    = 8'h61;
    localparam logic [7:0] ChUpperA    = 8'h41;
    localparam logic [7:0] ChUpperF    = 8'h46;
    localparam logic [7:0] ChDigit9    = 8'h39;
    localparam logic [7:0] ChLowerF    = 8'h66;
    localparam int DrainCycles = 8;

    logic clk;
    logic rst_n;

    jsu_escaped_if esc ();
    jsu_decoded_if dec ();

    json_string_unescape_utf8 u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .escaped (esc),
        .decoded (dec)
    );

    // decoder model state
    scan_mode_t  scan_mode;
    logic [2:0]  hex_taken;
    logic [15:0] code_acc;
    logic        hex_halted;

    dec_byte_t   decoded_due[$];
    int          decoded_inputs;
    int          fail_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    logic        start_next;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        dec.ready <= rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // output checker
    always @(posedge clk)
    begin
        dec_byte_t want;
        if (rst_n && dec.valid && dec.ready)
        begin
            if (decoded_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected output transfer: byte %02h last %0b",
                             dec.out_byte, dec.last_of_run);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (dec.out_byte !== want.data || dec.last_of_run !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, dec.out_byte, dec.last_of_run);
                end
            end
        end
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= ChDigit0 && c <= ChDigit9) return int'(c - ChDigit0);
        if (c >= ChLowerA && c <= ChLowerF) return int'(c - ChLowerA) + 10;
        if (c >= ChUpperA && c <= ChUpperF) return int'(c - ChUpperA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return ChDigit0 + 8'(nib);
        if ($urandom_range(0, 1) == 1) return ChLowerA + 8'(nib) - 8'd10;
        return ChUpperA + 8'(nib) - 8'd10;
    endfunction

    // works out the bytes one accepted input produces and queues them
    task automatic predict_decode(input logic [7:0] b, input logic st);
        logic [7:0] burst[$];
        int         d;
        if (st)
        begin
            scan_mode  = ModeText;
            hex_taken  = 3'd0;
            code_acc   = 16'd0;
            hex_halted = 1'b0;
        end
        if (scan_mode != ModeEnded)
            decoded_inputs++;
        case (scan_mode)
            ModeText:
            begin
                if (b == ChNul || b == ChQuote)
                    scan_mode = ModeEnded;
                else if (b == ChBackslash)
                    scan_mode = ModeEscape;
                else
                    burst.push_back(b);
            end
            ModeEscape:
            begin
                scan_mode = ModeText;
                case (b)
                    ChLetterN: burst.push_back(ChNewline);
                    ChLetterT: burst.push_back(ChTab);
                    ChLetterR: burst.push_back(ChReturn);
                    ChLetterU:
                    begin
                        scan_mode  = ModeHex;
                        hex_taken  = 3'd0;
                        code_acc   = 16'd0;
                        hex_halted = 1'b0;
                    end
                    ChNul:
                    begin
                        burst.push_back(ChNul);
                        scan_mode = ModeEnded;
                    end
                    default: burst.push_back(b);
                endcase
            end
            ModeHex:
            begin
                if (b == ChNul)
                begin
                    scan_mode = ModeEnded;
                    hex_taken = 3'd0;
                end
                else
                begin
                    if (!hex_halted)
                    begin
                        d = hex_value(b);
                        if (d < 0)
                            hex_halted = 1'b1;
                        else
                            code_acc = {code_acc[11:0], 4'(d)};
                    end
                    hex_taken = hex_taken + 3'd1;
                    if (hex_taken >= 3'd4)
                    begin
                        if (code_acc < Utf8Limit1)
                            burst.push_back(code_acc[7:0]);
                        else if (code_acc < Utf8Limit2)
                        begin
                            burst.push_back(Utf8Lead2 | {3'b000, code_acc[10:6]});
                            burst.push_back(Utf8Cont | {2'b00, code_acc[5:0] & Utf8Mask});
                        end
                        else
                        begin
                            burst.push_back(Utf8Lead3 | {4'b0000, code_acc[15:12]});
                            burst.push_back(Utf8Cont | {2'b00, code_acc[11:6] & Utf8Mask});
                            burst.push_back(Utf8Cont | {2'b00, code_acc[5:0] & Utf8Mask});
                        end
                        scan_mode = ModeText;
                        hex_taken = 3'd0;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < burst.size(); i++)
            decoded_due.push_back('{data: burst[i], last: (i == burst.size() - 1)});
    endtask

    // presents one byte and holds it until the transfer happens
    task automatic send_item(input logic [7:0] b, input logic st);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            esc.valid <= 1'b0;
            @(posedge clk);
        end
        esc.valid       <= 1'b1;
        esc.in_byte     <= b;
        esc.start_value <= st;
        @(posedge clk);
        while (!esc.ready)
            @(posedge clk);
        predict_decode(b, st);
    endtask

    task automatic put_char(input logic [7:0] b);
        send_item(b, start_next);
        start_next = 1'b0;
    endtask

    task automatic put_unicode(input logic [15:0] cp);
        put_char(ChBackslash);
        put_char(ChLetterU);
        put_char(hex_char(cp[15:12]));
        put_char(hex_char(cp[11:8]));
        put_char(hex_char(cp[7:4]));
        put_char(hex_char(cp[3:0]));
    endtask

    // sender holds off until every queued output byte is back
    task automatic drain_outputs();
        esc.valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic test_plain_and_end();
        // no start seen since reset, then a closing quote and an ignored byte
        start_next = 1'b0;
        put_char(8'hFF);
        put_char(ChQuote);
        put_char(ChLetterX);
        drain_outputs();
    endtask

    task automatic test_escapes();
        start_next = 1'b1;
        put_char(ChBackslash);
        put_char(ChLetterN);
        // backslash right before end of line
        put_char(ChBackslash);
        put_char(ChNul);
        drain_outputs();
    endtask

    task automatic test_unicode_forms();
        start_next = 1'b1;
        put_unicode(16'h00E9);
        put_unicode(16'hFFFF);
        // quote, letter and digits inside the four bytes; the quote halts the code at zero
        put_char(ChBackslash);
        put_char(ChLetterU);
        put_char(ChQuote);
        put_char(ChLetterZ);
        put_char(ChDigit0);
        put_char(ChDigit0);
        // escape cut short by end of line
        put_char(ChBackslash);
        put_char(ChLetterU);
        put_char(ChDigit0 + 8'd1);
        put_char(ChNul);
        drain_outputs();
    endtask

    task automatic random_token();
        logic [7:0]  b;
        logic [15:0] cp;
        int          n_hex;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5:
            begin
                do b = 8'($urandom_range(1, 255));
                while (b == ChQuote || b == ChBackslash);
                put_char(b);
            end
            6: put_char(8'($urandom_range(0, 255)));
            7, 8, 9:
            begin
                put_char(ChBackslash);
                case ($urandom_range(0, 6))
                    0: put_char(ChLetterN);
                    1: put_char(ChLetterT);
                    2: put_char(ChLetterR);
                    3: put_char(ChBackslash);
                    4: put_char(ChQuote);
                    5: put_char(ChSlash);
                    default:
                    begin
                        do b = 8'($urandom_range(1, 255));
                        while (b == ChLetterU);
                        put_char(b);
                    end
                endcase
            end
            10, 11, 12, 13:
            begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                put_unicode(cp);
            end
            14:
            begin
                // \u whose four bytes mix digits with other bytes
                put_char(ChBackslash);
                put_char(ChLetterU);
                repeat (4)
                begin
                    if ($urandom_range(0, 1) == 1)
                        put_char(hex_char(4'($urandom_range(0, 15))));
                    else
                        put_char(8'($urandom_range(1, 255)));
                end
            end
            default:
            begin
                put_char(ChBackslash);
                if ($urandom_range(0, 1) == 1)
                begin
                    put_char(ChLetterU);
                    n_hex = $urandom_range(0, 3);
                    repeat (n_hex) put_char(hex_char(4'($urandom_range(0, 15))));
                end
                put_char(ChNul);
            end
        endcase
    endtask

    task automatic random_value();
        start_next = 1'b1;
        repeat ($urandom_range(1, 12)) random_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: put_char(ChQuote);
            6, 7: put_char(ChNul);
            8: ;
            default:
            begin
                put_char(ChQuote);
                repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int goal;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal = decoded_inputs + n_items;
        while (decoded_inputs < goal)
            random_value();
        drain_outputs();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        esc.valid       = 1'b0;
        esc.in_byte     = 8'h00;
        esc.start_value = 1'b0;
        dec.ready       = 1'b0;
        scan_mode       = ModeText;
        hex_taken       = 3'd0;
        code_acc        = 16'd0;
        hex_halted      = 1'b0;
        decoded_inputs  = 0;
        fail_count      = 0;
        src_idle_pct    = 14;
        sink_idle_pct   = 48;
        start_next      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_end();
        test_escapes();
        test_unicode_forms();
        test_random_traffic(14, 48, 60);
        test_random_traffic(48, 14, 60);
        test_random_traffic(0, 0, 60);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_escaped_if.sv
hw/rtl/jsu_decoded_if.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_burst.sv
hw/rtl/json_string_unescape_utf8.sv
bench/testbench.sv
